>>> sv/sorted_bitmap_set_lookup_assert.svh
// Assertion macros for the sorted bitmap set lookup block.
// Used by the checker module; needs nothing else.
`ifndef SORTED_BITMAP_SET_LOOKUP_ASSERT_SVH
`define SORTED_BITMAP_SET_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SBSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SBSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sbsl_pkg.sv
// Package for the sorted bitmap set lookup block: field widths, opcodes,
// record layout and sequencer states. No dependencies.
`default_nettype none

package sbsl_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned OpW   = 2;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned BitsW = 64;
  localparam int unsigned IdW   = 14;
  localparam int unsigned BitW  = 6;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [BitsW-1:0] bits;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_FINAL = 3'b100
  } state_e;

endpackage

`default_nettype wire

>>> sv/sbsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module sbsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/sorted_bitmap_set_lookup.sv
// Top level of the sorted bitmap set lookup: record table, bisection
// sequencer and result register. Uses sbsl_pkg and sbsl_ram.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+------------------------------------
//  in      | in  | in_valid_i / in_stall_o  | opcode, record_key, record_bits,
//          |     |                          | query_id
//  out     | out | out_valid_o / out_stall_i| key_found, is_member
//
// Clear and append are done on acceptance. A query runs S bisection steps, S being at
// most floor(log2(count)) + 1 and zero for an empty table; one table read per step,
// then a final read. Reset clears the record count and the result valid flag; table
// contents stay undefined. A stalled result holds the block in its final step until
// the result register frees.
`default_nettype none

module sorted_bitmap_set_lookup
  import sbsl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OpW-1:0]   opcode_i,
  input  wire logic [KeyW-1:0]  record_key_i,
  input  wire logic [BitsW-1:0] record_bits_i,
  input  wire logic [IdW-1:0]   query_id_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  key_found_o,
  output logic                  is_member_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   first_q, first_d;
  logic [CW-1:0]   span_q, span_d;
  logic [CW-1:0]   mid_q, mid_d;
  logic [KeyW-1:0] qkey_q, qkey_d;
  logic [BitW-1:0] qbit_q, qbit_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic            member_q, member_d;

  logic            in_xfer;
  logic            out_free;
  logic            wr_en;
  logic            rd_en;
  logic [CW-1:0]   rd_addr;
  rec_t            wr_rec;
  logic [RecW-1:0] rd_raw;
  rec_t            rd_rec;
  logic [CW-1:0]   half;
  logic            key_lt;
  logic [CW-1:0]   step_first;
  logic [CW-1:0]   step_span;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_rec.key  = record_key_i;
  assign wr_rec.bits = record_bits_i;
  assign rd_rec      = rec_t'(rd_raw);

  // Record table
  sbsl_ram #(
    .WIDTH (RecW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (wr_rec),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr[AW-1:0]),
    .rd_data_o (rd_raw)
  );

  // One bisection step on the record just read at mid
  assign half       = span_q >> 1;
  assign key_lt     = rd_rec.key < qkey_q;
  assign step_first = key_lt ? (mid_q + CW'(1)) : first_q;
  assign step_span  = key_lt ? (span_q - CW'(1) - half) : half;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    first_d     = first_q;
    span_d      = span_q;
    mid_d       = mid_q;
    qkey_d      = qkey_q;
    qbit_d      = qbit_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    member_d    = member_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (opcode_i)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (count_q < CW'(TABLE_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_QUERY: begin
              qkey_d  = query_id_i[BitW +: KeyW];
              qbit_d  = query_id_i[BitW-1:0];
              first_d = '0;
              span_d  = count_q;
              mid_d   = count_q >> 1;
              rd_en   = 1'b1;
              if (count_q != '0) begin
                rd_addr = mid_d;
                state_d = S_PROBE;
              end else begin
                rd_addr = '0;
                state_d = S_FINAL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PROBE: begin
        first_d = step_first;
        span_d  = step_span;
        mid_d   = step_first + (step_span >> 1);
        rd_en   = 1'b1;
        if (step_span != '0) begin
          rd_addr = mid_d;
        end else begin
          rd_addr = step_first;
          state_d = S_FINAL;
        end
      end

      S_FINAL: begin
        // Hold here until the result register can take the answer
        if (out_free) begin
          found_d     = (first_q < count_q) && (rd_rec.key == qkey_q);
          member_d    = found_d && rd_rec.bits[qbit_q];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    span_q   <= span_d;
    mid_q    <= mid_d;
    qkey_q   <= qkey_d;
    qbit_q   <= qbit_d;
    found_q  <= found_d;
    member_q <= member_d;
  end

  assign out_valid_o = out_valid_q;
  assign key_found_o = found_q;
  assign is_member_o = member_q;

endmodule

`default_nettype wire

>>> sv/sbsl_checker.sv
// Port-level checker for the sorted bitmap set lookup, bound to the top level.
// Uses sbsl_pkg and the macros in sorted_bitmap_set_lookup_assert.svh.
`default_nettype none

`include "sorted_bitmap_set_lookup_assert.svh"

module sbsl_checker
  import sbsl_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [OpW-1:0]   opcode_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             key_found_o,
  input wire logic             is_member_o
);

  logic query_xfer;

  assign query_xfer = in_valid_i && !in_stall_o && (opcode_i == OP_QUERY);

  // Hold a stalled result
  `SBSL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(key_found_o) && $stable(is_member_o),
    "stalled result changed")

  // Membership only where the key was found
  `SBSL_ASSERT_NOW(a_member_found, clk_i, rst_ni, out_valid_o && is_member_o,
    key_found_o, "member reported without key found")

  // Stall the input while a query is being searched
  `SBSL_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_xfer, in_stall_o,
    "input not stalled after query transfer")

  // Free the input as soon as a result is loaded
  `SBSL_ASSERT_NOW(a_done_free, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o,
    "input still stalled after result loaded")

endmodule

bind sorted_bitmap_set_lookup sbsl_checker u_sbsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .key_found_o (key_found_o),
  .is_member_o (is_member_o)
);

`default_nettype wire

>>> test/tb.sv
// Testbench for sorted_bitmap_set_lookup: drives clear, append and query transfers,
// predicts every answer with a local model of the record table and its bisection.
// Depends on sbsl_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
  import sbsl_pkg::*;

  localparam int unsigned Depth       = TableDepthDefault;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 32;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct {
    logic found;
    logic member;
  } answer_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [OpW-1:0]   opcode      = '0;
  logic [KeyW-1:0]  record_key  = '0;
  logic [BitsW-1:0] record_bits = '0;
  logic [IdW-1:0]   query_id    = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             key_found;
  logic             is_member;

  // Model of the record table
  logic [KeyW-1:0]  tbl_key  [Depth];
  logic [BitsW-1:0] tbl_bits [Depth];
  int unsigned      tbl_count;

  answer_t     pending_answers[$];
  int unsigned idle_pct;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_appends;
  int unsigned n_dropped;
  int unsigned n_clears;

  sorted_bitmap_set_lookup dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .record_key_i (record_key),
    .record_bits_i(record_bits),
    .query_id_i   (query_id),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .key_found_o  (key_found),
    .is_member_o  (is_member)
  );

  always #2 clk = ~clk;

  // Lower-bound bisection exactly as the block runs it, sorted or not
  function automatic int unsigned bisect_lower(input logic [KeyW-1:0] key);
    int unsigned first, span, half, mid;
    first = 0;
    span  = tbl_count;
    while (span > 0) begin
      half = span >> 1;
      mid  = first + half;
      if (mid < Depth && tbl_key[mid] < key) begin
        first = mid + 1;
        span  = span - 1 - half;
      end else begin
        span = half;
      end
    end
    return first;
  endfunction

  // Advance the table model by one accepted transfer; queue the answer of a query
  task automatic apply_to_table(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                                input logic [BitsW-1:0] bits, input logic [IdW-1:0] id);
    answer_t     ans;
    int unsigned pos;
    logic [KeyW-1:0] qkey;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
        n_clears++;
      end
      OP_APPEND: begin
        if (tbl_count < Depth) begin
          tbl_key[tbl_count]  = key;
          tbl_bits[tbl_count] = bits;
          tbl_count++;
          n_appends++;
        end else begin
          n_dropped++;
        end
      end
      OP_QUERY: begin
        qkey       = id[IdW-1:BitW];
        pos        = bisect_lower(qkey);
        ans.found  = 1'b0;
        ans.member = 1'b0;
        if (pos < tbl_count && pos < Depth && tbl_key[pos] == qkey) begin
          ans.found  = 1'b1;
          ans.member = tbl_bits[pos][id[BitW-1:0]];
        end
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // Present one transfer, hold it until accepted, then maybe idle for a burst
  task automatic send_item(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                           input logic [BitsW-1:0] bits, input logic [IdW-1:0] id);
    int unsigned gap;
    opcode      <= op;
    record_key  <= key;
    record_bits <= bits;
    query_id    <= id;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_to_table(op, key, bits, id);
    if (op != OpUnused) n_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [BitsW-1:0] rand_bits();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_clear();
    send_item(OP_CLEAR, KeyW'($urandom_range(0, 255)), rand_bits(),
              IdW'($urandom_range(0, 16383)));
  endtask

  task automatic send_append(input logic [KeyW-1:0] key, input logic [BitsW-1:0] bits);
    send_item(OP_APPEND, key, bits, IdW'($urandom_range(0, 16383)));
  endtask

  task automatic send_query(input logic [KeyW-1:0] key, input logic [BitW-1:0] bit_idx);
    send_item(OP_QUERY, KeyW'($urandom_range(0, 255)), rand_bits(), {key, bit_idx});
  endtask

  // Mostly keys held in the table, some neighbours, some anything
  function automatic logic [KeyW-1:0] pick_query_key();
    int unsigned r;
    int          k;
    r = $urandom_range(0, 99);
    if (tbl_count == 0 || r >= 85) return KeyW'($urandom_range(0, 255));
    k = int'(tbl_key[$urandom_range(0, tbl_count - 1)]);
    if (r >= 60) k = $urandom_range(0, 1) ? k + 1 : k - 1;
    if (k < 0) k = 0;
    if (k > 255) k = 255;
    return k[KeyW-1:0];
  endfunction

  task automatic run_queries(input int unsigned count);
    repeat (count) send_query(pick_query_key(), BitW'($urandom_range(0, 63)));
  endtask

  // Check each result transfer against the oldest expected answer
  always @(posedge clk) begin
    answer_t ans;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: key_found %0b, is_member %0b", key_found, is_member);
        n_errors++;
      end else begin
        ans = pending_answers.pop_front();
        n_checked++;
        if (key_found !== ans.found) begin
          $error("key_found: expected %0b, got %0b", ans.found, key_found);
          n_errors++;
        end
        if (is_member !== ans.member) begin
          $error("is_member: expected %0b, got %0b", ans.member, is_member);
          n_errors++;
        end
      end
    end
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 199) < idle_pct) begin
      stall_left = $urandom_range(1, 19);
    end
    out_stall <= (stall_left > 0);
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Queries on an empty table, after reset and after a clear
  task automatic test_empty_table();
    idle_pct = 30;
    send_query(8'h00, 6'd0);
    send_clear();
    send_query(8'hFF, 6'd63);
    send_query(8'h00, 6'd0);
  endtask

  // Extreme keys, bitmaps and bit indexes; unused opcode dropped
  task automatic test_extremes();
    send_clear();
    send_append(8'h00, '0);
    send_append(8'h80, '1);
    send_append(8'hFF, 64'h8000_0000_0000_0001);
    send_query(8'h00, 6'd0);
    send_query(8'h80, 6'd63);
    send_query(8'hFF, 6'd0);
    send_query(8'hFF, 6'd63);
    send_query(8'hFF, 6'd1);
    send_item(OpUnused, 8'hFF, '1, '1);
    send_query(8'h40, 6'd5);
    send_query(8'h80, 6'd0);
  endtask

  // Unsorted table: answers follow the probes alone
  task automatic test_unsorted();
    send_clear();
    send_append(8'd9, '1);
    send_append(8'd3, '1);
    send_append(8'd7, '1);
    send_append(8'd1, '1);
    send_query(8'd9, 6'd0);
    send_query(8'd3, 6'd1);
    send_query(8'd7, 6'd2);
    send_query(8'd1, 6'd3);
  endtask

  // Fill the table, then append to a full table and query it
  task automatic test_full_table();
    send_clear();
    for (int i = 0; i < Depth; i++) send_append(i[KeyW-1:0], rand_bits());
    send_append(8'h00, '1);
    send_append(8'hFF, '0);
    send_append(8'h10, '1);
    send_query(8'hFF, 6'd63);
    send_query(8'h00, 6'd0);
    run_queries(20);
  endtask

  // Random sequences: mostly clear, sorted appends, queries; some unsorted and noise
  task automatic test_random_sequences(input int unsigned target);
    int unsigned start, kind, n_rec, step, next_k;
    start = n_sent;
    while (n_sent - start < target) begin
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_clear();
        n_rec  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        step   = $urandom_range(0, 1) ? 3 : 40;
        next_k = $urandom_range(0, 40);
        repeat (n_rec) begin
          send_append(next_k[KeyW-1:0], rand_bits());
          next_k = next_k + $urandom_range(0, step);
          if (next_k > 255) next_k = 255;
        end
        run_queries($urandom_range(1, 10));
      end else if (kind < 85) begin
        send_clear();
        repeat ($urandom_range(0, 12)) send_append(KeyW'($urandom_range(0, 15)), rand_bits());
        run_queries($urandom_range(1, 8));
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(OpW'($urandom_range(0, 3)), KeyW'($urandom_range(0, 255)), rand_bits(),
                    IdW'($urandom_range(0, 16383)));
      end
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_tail();
    idle_pct = 0;
    send_clear();
    for (int i = 0; i < 8; i++) send_append(8'(i * 30), rand_bits());
    run_queries(20);
  endtask

  initial begin
    tbl_count    = 0;
    idle_pct     = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    n_errors     = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_appends    = 0;
    n_dropped    = 0;
    n_clears     = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_unsorted();
    test_full_table();
    test_random_sequences(300);
    test_tail();

    // Drop valid and drain the outstanding answers
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected answers never arrived", pending_answers.size());
      n_errors++;
    end

    $display("tb: %0d transfers sent, %0d query answers checked", n_sent, n_checked);
    $display("tb: %0d records appended, %0d dropped on a full table, %0d clears",
             n_appends, n_dropped, n_clears);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
